### hdl/idl_pkg.sv
// ----------------------------------------------------------------------------
// idl_pkg - shared types and constants for the indexed insert/delete list
// Operation and status codes, cell command codes and fixed field widths.
// ----------------------------------------------------------------------------
package idl_pkg;

  // Fixed widths of the transaction fields
  localparam int OP_W      = 3;
  localparam int POS_W     = 5;
  localparam int ELEM_W    = 32;
  localparam int STAT_W    = 2;
  localparam int HELD_W    = 5;

  // Defaults for the top-level parameters
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 3'd0,
    OP_INSERT    = 3'd1,
    OP_DELETE    = 3'd2,
    OP_PUSH_HEAD = 3'd3,
    OP_PUSH_END  = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cell_cmd_t;

  // Decoded control from the controller to the top level
  typedef struct packed {
    cell_cmd_t cmd;
    logic      rd_en;
    status_t   status;
  } ctrl_t;

endpackage

### hdl/idl_req_if.sv
// ----------------------------------------------------------------------------
// idl_req_if - request channel
// Carries one list operation per transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface idl_req_if;
  import idl_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [POS_W-1:0]  position;
  logic [ELEM_W-1:0] element;

  modport source (output valid, output operation, output position, output element,
                  input ready);
  modport sink   (input valid, input operation, input position, input element,
                  output ready);
endinterface

### hdl/idl_rsp_if.sv
// ----------------------------------------------------------------------------
// idl_rsp_if - response channel
// Carries one result per transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface idl_rsp_if;
  import idl_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] read_value;
  logic [STAT_W-1:0] status;
  logic [HELD_W-1:0] entries_held;

  modport source (output valid, output read_value, output status, output entries_held,
                  input ready);
  modport sink   (input valid, input read_value, input status, input entries_held,
                  output ready);
endinterface

### hdl/indexed_insert_delete_list_unit.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_unit - ordered word list with indexed access
// Row of shift cells with a central controller and a registered response.
// ----------------------------------------------------------------------------
// The unit keeps up to CAPACITY words in order and completes one operation
// (read, insert, delete, push head, push end) per clock cycle as results are
// taken: every cell shifts, loads or holds in the same cycle, and the result
// is registered for the next cycle. A request is taken while the previous
// result waits in the response register as long as that result is taken in
// the same cycle. Rejected operations (full, empty, out of range) leave the
// list unchanged. The list is empty after reset; no clearing pass is needed.
module indexed_insert_delete_list_unit
  import idl_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input logic       clk,
  input logic       rst,
  idl_req_if.sink   req,
  idl_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  ctrl_t                 ctrl;
  logic [IDX_W-1:0]      cell_pos;
  logic [CNT_W-1:0]      count_next;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic                  accept;
  logic                  rsp_valid;
  logic [ELEM_W-1:0]     read_value;
  logic [STAT_W-1:0]     status;
  logic [HELD_W-1:0]     entries_held;

  // Take a new request when the response register is free or draining
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign word      = DATA_WIDTH'(req.element);

  idl_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (req.operation),
    .position   (req.position),
    .ctrl       (ctrl),
    .cell_pos   (cell_pos),
    .count_next (count_next)
  );

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower;
    logic [DATA_WIDTH-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = word;
    end else begin : g_mid_lo
      assign lower = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_q[i];
    end else begin : g_mid_hi
      assign upper = cell_q[i+1];
    end
    idl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (ctrl.cmd),
      .pos   (cell_pos),
      .word  (word),
      .lower (lower),
      .upper (upper),
      .q     (cell_q[i])
    );
  end

  // Hold the result until the response transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Capture the word at the checked read index, the status and the word count
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value   <= ctrl.rd_en ? ELEM_W'(cell_q[cell_pos]) : '0;
      status       <= ctrl.status;
      entries_held <= HELD_W'(count_next);
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.read_value   = read_value;
  assign rsp.status       = status;
  assign rsp.entries_held = entries_held;

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ready |=> rsp_valid)
    else $error("pending result lost");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    accept && !ctrl.rd_en |=> read_value == '0)
    else $error("nonzero read value for a non-read result");

  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    accept && ctrl.status != ST_OK |-> ctrl.cmd == CMD_HOLD)
    else $error("rejected operation moved the cells");

endmodule

### hdl/idl_cell.sv
// ----------------------------------------------------------------------------
// idl_cell - one storage cell of the list chain
// Holds one word; on insert takes the word from its lower neighbor or the new
// word, on delete takes the word from its upper neighbor.
// ----------------------------------------------------------------------------
module idl_cell
  import idl_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int IDX_W      = 4,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [IDX_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] lower,
  input  logic [DATA_WIDTH-1:0] upper,
  output logic [DATA_WIDTH-1:0] q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  // Shift up, load, shift down or hold
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_INSERT: begin
        if (MY_IDX > pos) begin
          q <= lower;
        end else if (MY_IDX == pos) begin
          q <= word;
        end
      end
      CMD_DELETE: begin
        if (MY_IDX >= pos) begin
          q <= upper;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

### hdl/idl_ctrl.sv
// ----------------------------------------------------------------------------
// idl_ctrl - list controller
// Decodes the operation, checks fullness, emptiness and range, owns the word
// count and broadcasts the cell command and index to the chain.
// ----------------------------------------------------------------------------
module idl_ctrl
  import idl_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [OP_W-1:0]  operation,
  input  logic [POS_W-1:0] position,
  output ctrl_t            ctrl,
  output logic [IDX_W-1:0] cell_pos,
  output logic [CNT_W-1:0] count_next
);

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;
  logic             empty;
  ctrl_t            dec;

  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(count);
  assign full    = (count == CAP_CNT);
  assign empty   = (count == '0);

  // Decode operation and check limits
  always_comb begin
    dec        = '{cmd: CMD_HOLD, rd_en: 1'b0, status: ST_OK};
    cell_pos   = pos_ext[IDX_W-1:0];
    count_next = count;
    case (op_t'(operation))
      OP_READ: begin
        if (empty) begin
          dec.status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          dec.status = ST_RANGE;
        end else begin
          dec.rd_en = 1'b1;
        end
      end
      OP_INSERT: begin
        if (full) begin
          dec.status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          dec.status = ST_RANGE;
        end else begin
          dec.cmd    = CMD_INSERT;
          count_next = count + 1'b1;
        end
      end
      OP_DELETE: begin
        if (empty) begin
          dec.status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          dec.status = ST_RANGE;
        end else begin
          dec.cmd    = CMD_DELETE;
          count_next = count - 1'b1;
        end
      end
      OP_PUSH_HEAD: begin
        if (full) begin
          dec.status = ST_FULL;
        end else begin
          dec.cmd    = CMD_INSERT;
          cell_pos   = '0;
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_END: begin
        if (full) begin
          dec.status = ST_FULL;
        end else begin
          dec.cmd    = CMD_INSERT;
          cell_pos   = count[IDX_W-1:0];
          count_next = count + 1'b1;
        end
      end
      default: begin
        dec = '{cmd: CMD_HOLD, rd_en: 1'b0, status: ST_OK};
      end
    endcase
  end

  // Gate the cell command with the handshake
  always_comb begin
    ctrl     = dec;
    ctrl.cmd = accept ? dec.cmd : CMD_HOLD;
  end

  // Advance the word count on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("word count above capacity");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("word count changed without a transaction");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    accept && dec.status == ST_FULL |=> count == $past(count))
    else $error("rejected insert changed the count");

  a_delete_dec: assert property (@(posedge clk) disable iff (rst)
    accept && ctrl.cmd == CMD_DELETE |=> count == $past(count) - 1'b1)
    else $error("delete did not drop one word");

endmodule
